// File: rtl/desv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// desv_pkg
// Shared types, tables and helper functions for the block cipher pipeline.
// ----------------------------------------------------------------------------
package desv_pkg;

	localparam int unsigned Rounds = 16;
	localparam logic [15:0] ShiftsEnc = 16'hc081;
	localparam logic [15:0] ShiftsDec = 16'h8103;

	typedef enum logic [0:0] {
		CFG_KEY_BITS  = 1'b0,
		CFG_KEY_TWEAK = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] lh;
		logic [31:0] rh;
		logic [27:0] c;
		logic [27:0] d;
		logic        fp;
		logic        rev;
		logic        hsw;
	} rnd_state_t;

	function automatic logic [7:0] pc2_idx(input int unsigned n);
		logic [7:0] tab [0:47];
		tab = '{8'd14, 8'd17, 8'd11, 8'd24, 8'd1, 8'd5, 8'd3, 8'd28, 8'd15, 8'd6, 8'd21, 8'd10,
			8'd23, 8'd19, 8'd12, 8'd4, 8'd26, 8'd8, 8'd16, 8'd7, 8'd27, 8'd20, 8'd13, 8'd2,
			8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
			8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32};
		return tab[n];
	endfunction

	function automatic logic [7:0] perm_idx(input int unsigned n);
		logic [7:0] tab [0:31];
		tab = '{8'd16, 8'd7, 8'd20, 8'd21, 8'd29, 8'd12, 8'd28, 8'd17, 8'd1, 8'd15, 8'd23,
			8'd26, 8'd5, 8'd18, 8'd31, 8'd10, 8'd2, 8'd8, 8'd24, 8'd14, 8'd32, 8'd27, 8'd3,
			8'd9, 8'd19, 8'd13, 8'd30, 8'd6, 8'd22, 8'd11, 8'd4, 8'd25};
		return tab[n];
	endfunction

	function automatic logic [7:0] sbox_pair(input logic [1:0] box, input logic [5:0] v);
		logic [7:0] t0 [0:63];
		logic [7:0] t1 [0:63];
		logic [7:0] t2 [0:63];
		logic [7:0] t3 [0:63];
		logic [7:0] r;
		t0 = '{8'h2e,8'he0,8'hc4,8'hbf,8'h4d,8'h27,8'h11,8'hc4,8'h72,8'h4e,8'haf,8'h72,8'hbb,
			8'hdd,8'h68,8'h11,8'h83,8'h5a,8'h5a,8'h06,8'h36,8'hfc,8'hfc,8'hab,8'hd5,8'h39,
			8'h09,8'h95,8'he0,8'h83,8'h97,8'h68,8'h44,8'hbf,8'h21,8'h8c,8'h1e,8'hc8,8'hb8,
			8'h72,8'had,8'h14,8'hd6,8'he9,8'h72,8'h21,8'h8b,8'hd7,8'hff,8'h65,8'h9c,8'hfb,
			8'hc9,8'h03,8'h57,8'h9e,8'h63,8'haa,8'h3a,8'h40,8'h05,8'h56,8'he0,8'h3d};
		t1 = '{8'hcf,8'ha3,8'h11,8'hfd,8'ha8,8'h44,8'hfe,8'h27,8'h96,8'h7f,8'h2b,8'hc2,8'h63,
			8'h98,8'h84,8'h5e,8'h09,8'h6c,8'hd7,8'h10,8'h32,8'hd1,8'h4d,8'hea,8'hec,8'h06,
			8'h70,8'hb9,8'h55,8'h3b,8'hba,8'h85,8'h90,8'h4d,8'hee,8'h38,8'hf7,8'h2a,8'h5b,
			8'hc1,8'h2a,8'h93,8'h84,8'h5f,8'hcd,8'hf4,8'h31,8'ha2,8'h75,8'hbb,8'h08,8'he6,
			8'h4c,8'h17,8'ha6,8'h7c,8'h19,8'h60,8'hd3,8'h05,8'hb2,8'h8e,8'h6f,8'hd9};
		t2 = '{8'h4a,8'hdd,8'hb0,8'h07,8'h29,8'hb0,8'hee,8'h79,8'hf6,8'h43,8'h03,8'h94,8'h8f,
			8'h16,8'hd5,8'haa,8'h31,8'he2,8'hcd,8'h38,8'h9c,8'h55,8'h77,8'hce,8'h5b,8'h2c,
			8'ha4,8'hfb,8'h62,8'h8f,8'h18,8'h61,8'h1d,8'h61,8'h46,8'hba,8'hb4,8'hdd,8'hd9,
			8'h80,8'hc8,8'h16,8'h3f,8'h49,8'h73,8'ha8,8'he0,8'h77,8'hab,8'h94,8'hf1,8'h5f,
			8'h62,8'h0e,8'h8c,8'hf3,8'h05,8'heb,8'h5a,8'h25,8'h9e,8'h32,8'h27,8'hcc};
		t3 = '{8'hd7,8'h1d,8'h2d,8'hf8,8'h8e,8'hdb,8'h43,8'h85,8'h60,8'ha6,8'hf6,8'h3f,8'hb9,
			8'h70,8'h1a,8'h43,8'ha1,8'hc4,8'h92,8'h57,8'h38,8'h62,8'he5,8'hbc,8'h5b,8'h01,
			8'h0c,8'hea,8'hc4,8'h9e,8'h7f,8'h29,8'h7a,8'h23,8'hb6,8'h1f,8'h49,8'he0,8'h10,
			8'h76,8'h9c,8'h4a,8'hcb,8'ha1,8'he7,8'h8d,8'h2d,8'hd8,8'h0f,8'hf9,8'h61,8'hc4,
			8'ha3,8'h95,8'hde,8'h0b,8'hf5,8'h3c,8'h32,8'h57,8'h58,8'h62,8'h84,8'hbe};
		case (box)
			2'd0:    r = t0[v];
			2'd1:    r = t1[v];
			2'd2:    r = t2[v];
			default: r = t3[v];
		endcase
		return r;
	endfunction

	function automatic logic [2:0] ip_src(input int unsigned m);
		logic [2:0] tab [0:7];
		tab = '{3'd6, 3'd4, 3'd2, 3'd0, 3'd7, 3'd5, 3'd3, 3'd1};
		return tab[m];
	endfunction

	function automatic logic [63:0] init_perm(input logic [63:0] blk);
		logic [63:0] o;
		o = '0;
		for (int m = 0; m < 8; m++)
			for (int i = 0; i < 8; i++)
				o[63 - 8*m - 7 + i] = blk[63 - 8*i - 7 + ip_src(m)];
		return o;
	endfunction

	function automatic logic [63:0] final_perm(input logic [63:0] blk);
		logic [63:0] o;
		o = '0;
		for (int m = 0; m < 8; m++)
			for (int i = 0; i < 8; i++)
				o[63 - 8*i - 7 + ip_src(m)] = blk[63 - 8*m - 7 + i];
		return o;
	endfunction

	function automatic logic [27:0] rotl28(input logic [27:0] x, input logic two);
		return two ? {x[25:0], x[27:26]} : {x[26:0], x[27]};
	endfunction

	function automatic logic [27:0] rotr28(input logic [27:0] x, input logic two);
		return two ? {x[1:0], x[27:2]} : {x[0], x[27:1]};
	endfunction

endpackage
`default_nettype wire

// File: rtl/desv_round_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// desv_round_cell
// One Feistel round with its key rotation, registered at the output.
// ----------------------------------------------------------------------------
module desv_round_cell #(
	parameter int unsigned RoundIdx = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic                  vld_in,
	input  wire desv_pkg::rnd_state_t  st_in,
	input  wire logic [7:0]            tweak,
	output logic                       vld_q,
	output desv_pkg::rnd_state_t       st_q
);
	import desv_pkg::*;

	logic                enc_two;
	logic                dec_two;
	logic [27:0]         c_k;
	logic [27:0]         d_k;
	logic [55:0]         cd;
	logic [47:0]         subkey;
	logic [15:0]         prod;
	logic [7:0]          lo;
	logic [7:0]          hi;
	logic [7:0]          tb;
	logic [31:0]         x;
	logic [31:0]         s;
	logic [31:0]         f;
	logic [5:0]          v;
	logic [7:0]          b;
	rnd_state_t          nxt;

	assign enc_two = !ShiftsEnc[15 - RoundIdx];
	assign dec_two = !ShiftsDec[15 - RoundIdx];
	assign c_k = st_in.rev ? st_in.c : rotl28(st_in.c, enc_two);
	assign d_k = st_in.rev ? st_in.d : rotl28(st_in.d, enc_two);
	assign cd  = {c_k, d_k};
	assign prod = 16'({8'd0, tweak} + 16'd1) * 16'({8'd0, st_in.rh[31:24]} + 16'd1) - 16'd1;
	assign lo = prod[7:0];
	assign hi = prod[15:8];
	assign tb = (tweak == 8'd0) ? st_in.rh[31:24] : (lo - hi + ((lo < hi) ? 8'd1 : 8'd0));
	assign x  = {tb, st_in.rh[23:0]};

	always_comb begin
		for (int n = 0; n < 48; n++)
			subkey[47 - n] = cd[56 - 32'(pc2_idx(n))];
		s = '0;
		for (int i = 0; i < 8; i++) begin
			for (int j = 0; j < 6; j++)
				v[5 - j] = x[32 - (((4*i + j + 31) & 31) + 1)];
			v = v ^ subkey[47 - 6*i -: 6];
			b = sbox_pair(2'(i & 3), v);
			s[31 - 4*i -: 4] = (i > 3) ? b[7:4] : b[3:0];
		end
		for (int n = 0; n < 32; n++)
			f[31 - n] = s[32 - 32'(perm_idx(n))];
		if (st_in.hsw)
			f = {f[23:16], f[31:24], f[15:0]};
		nxt     = st_in;
		nxt.lh  = st_in.rh;
		nxt.rh  = st_in.lh ^ f;
		nxt.c   = st_in.rev ? rotr28(st_in.c, dec_two) : c_k;
		nxt.d   = st_in.rev ? rotr28(st_in.d, dec_two) : d_k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// File: rtl/des_block_cipher_variant.sv
`default_nettype none
// ----------------------------------------------------------------------------
// des_block_cipher_variant
// Sixteen-round DES-style block transform as a chain of round cells.
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | request   | in_valid, in_stall, data_block, flags
// out     | result    | out_valid, out_stall, out_block
// cfg     | write     | cfg_we, cfg_idx, cfg_data
//
// One request per cycle while in_stall is low; a request passes sixteen round
// cells, then the output register. The chain advances as a whole whenever the
// output register is free or taken; else every stage holds. Reset clears valid bits.
// ----------------------------------------------------------------------------
module des_block_cipher_variant (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [55:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] data_block,
	input  wire logic        use_initial_perm,
	input  wire logic        use_final_perm,
	input  wire logic        reverse_schedule,
	input  wire logic        hash_swap,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      out_block
);
	import desv_pkg::*;

	logic [55:0] key_q;
	logic [7:0]  tweak_q;
	logic        adv;
	logic [63:0] pre;
	logic        vld   [0:Rounds];
	rnd_state_t  st    [0:Rounds];
	logic [63:0] blk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			tweak_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_KEY_BITS:  key_q   <= cfg_data;
				CFG_KEY_TWEAK: tweak_q <= cfg_data[7:0];
				default:       key_q   <= key_q;
			endcase
		end
	end

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign pre      = use_initial_perm ? init_perm(data_block) : data_block;

	assign vld[0]    = in_valid;
	assign st[0].lh  = pre[63:32];
	assign st[0].rh  = pre[31:0];
	assign st[0].c   = key_q[55:28];
	assign st[0].d   = key_q[27:0];
	assign st[0].fp  = use_final_perm;
	assign st[0].rev = reverse_schedule;
	assign st[0].hsw = hash_swap;

	for (genvar r = 0; r < Rounds; r++) begin : g_cell
		desv_round_cell #(.RoundIdx(r)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.vld_in (vld[r]),
			.st_in  (st[r]),
			.tweak  (tweak_q),
			.vld_q  (vld[r+1]),
			.st_q   (st[r+1])
		);
	end

	assign blk = {st[Rounds].rh, st[Rounds].lh};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld[Rounds];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_block <= st[Rounds].fp ? final_perm(blk) : blk;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_block))
		else $error("result dropped under stall");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall mismatch");
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |=> out_valid == $past(vld[Rounds]))
		else $error("chain did not advance");

endmodule
`default_nettype wire
